@@ hdl/art_pkg.sv @@
package art_pkg;

	localparam int TableDepthDefault = 32;
	localparam logic [15:0] StaleReset = 16'd20;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_REFRESHED = 3'd1,
		ST_IMPROVED  = 3'd2,
		ST_IGNORED   = 3'd3,
		ST_FULL      = 3'd4,
		ST_FOUND     = 3'd5,
		ST_NOT_FOUND = 3'd6
	} status_t;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [31:0] dest_ip;
		logic [47:0] next_hop_mac;
		logic [7:0]  hops;
		logic [7:0]  iface;
		logic [31:0] now_seconds;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  found_hops;
		logic [47:0] found_mac;
		logic [7:0]  found_iface;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture request, clear scan results
		logic rd;      // issue read at scan index
		logic chk;     // evaluate read data of previous index
		logic wr;      // write back decided entry
		logic rsp;     // form response
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last;    // scan index at final entry
	} dp_sts_t;

endpackage

@@ hdl/aging_route_table_top.sv @@
// A request is scanned against the table one entry per cycle through the
// one-port table memory, then the last entry is checked, the decided entry is
// written back and the response is formed and held while out_stall is high.
// The input stalls until the result transfers, so one request is in flight.
// Reset: asynchronous, active low; all entries invalid, stale_seconds = 20.
module aging_route_table_top #(
	parameter int TABLE_DEPTH = art_pkg::TableDepthDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  art_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output art_pkg::rsp_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [15:0]   cfg_data
);
	import art_pkg::*;

	logic [15:0] stale_q;
	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) stale_q <= StaleReset;
		else if (cfg_valid && cfg_ready) stale_q <= cfg_data;
	end

	art_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
	);

	art_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk, .arst_n, .req(in_data), .stale_q_in(stale_q), .cmd(cmd), .sts,
		.rsp(out_data)
	);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");
	a_onecmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.wr, cmd.rsp}))
		else $error("conflicting datapath commands");

endmodule

@@ hdl/art_datapath.sv @@
module art_datapath #(
	parameter int TABLE_DEPTH = art_pkg::TableDepthDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  art_pkg::req_t   req,
	input  logic [15:0]     stale_q_in,
	input  art_pkg::dp_cmd_t cmd,
	output art_pkg::dp_sts_t sts,
	output art_pkg::rsp_t   rsp
);
	import art_pkg::*;

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
		logic [7:0]  hops;
		logic [7:0]  iface;
		logic [31:0] stamp;
	} ent_t;

	ent_t mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;

	req_t        req_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] ridx_q;
	ent_t        rdata_q;
	logic        hit_q, free_ok_q;
	logic [IW-1:0] hit_idx_q, free_idx_q;
	ent_t        hit_ent_q;

	logic [31:0] age;
	logic        live, match;
	assign age   = req_q.now_seconds - rdata_q.stamp;
	assign live  = valid_q[ridx_q] && (age <= {16'd0, stale_q_in});
	assign match = live && (rdata_q.ip == req_q.dest_ip);

	assign sts.last = (idx_q == IW'(TABLE_DEPTH - 1));

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_q <= mem[idx_q];
		end
		if (cmd.wr && req_q.cmd == CMD_UPDATE) begin
			if (!hit_q && free_ok_q) begin
				mem[free_idx_q] <= '{req_q.dest_ip, req_q.next_hop_mac, req_q.hops,
					req_q.iface, req_q.now_seconds};
			end else if (hit_q && hit_ent_q.hops >= req_q.hops) begin
				mem[hit_idx_q] <= '{req_q.dest_ip, req_q.next_hop_mac, req_q.hops,
					req_q.iface, req_q.now_seconds};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			req_q <= '0;
			idx_q <= '0;
			ridx_q <= '0;
			hit_q <= 1'b0;
			free_ok_q <= 1'b0;
			hit_idx_q <= '0;
			free_idx_q <= '0;
			hit_ent_q <= '0;
			rsp <= '0;
		end else begin
			if (cmd.load) begin
				req_q <= req;
				idx_q <= '0;
				hit_q <= 1'b0;
				free_ok_q <= 1'b0;
			end
			if (cmd.rd) begin
				ridx_q <= idx_q;
				if (!sts.last) idx_q <= idx_q + 1'b1;
			end
			if (cmd.chk) begin
				// purge stale entries on the fly
				if (!live) valid_q[ridx_q] <= 1'b0;
				if (match && !hit_q) begin
					hit_q <= 1'b1;
					hit_idx_q <= ridx_q;
					hit_ent_q <= rdata_q;
				end
				if (!live && !free_ok_q) begin
					free_ok_q <= 1'b1;
					free_idx_q <= ridx_q;
				end
			end
			if (cmd.wr && req_q.cmd == CMD_UPDATE && !hit_q && free_ok_q) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (cmd.rsp) begin
				if (req_q.cmd == CMD_LOOKUP) begin
					rsp <= hit_q ? '{ST_FOUND, hit_ent_q.hops, hit_ent_q.mac, hit_ent_q.iface}
						: '{ST_NOT_FOUND, 8'd0, 48'd0, 8'd0};
				end else if (!hit_q) begin
					rsp <= free_ok_q ? '{ST_INSERTED, req_q.hops, req_q.next_hop_mac, req_q.iface}
						: '{ST_FULL, 8'd0, 48'd0, 8'd0};
				end else if (hit_ent_q.hops == req_q.hops) begin
					rsp <= '{ST_REFRESHED, req_q.hops, req_q.next_hop_mac, req_q.iface};
				end else if (hit_ent_q.hops > req_q.hops) begin
					rsp <= '{ST_IMPROVED, req_q.hops, req_q.next_hop_mac, req_q.iface};
				end else begin
					rsp <= '{ST_IGNORED, hit_ent_q.hops, hit_ent_q.mac, hit_ent_q.iface};
				end
			end
		end
	end

endmodule

@@ hdl/art_ctrl.sv @@
module art_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  art_pkg::dp_sts_t sts,
	output art_pkg::dp_cmd_t cmd
);
	import art_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_WR, S_RSP, S_OUT} state_t;
	state_t state_q;
	logic first_q;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	// check overlaps the next read: data of index i is checked while i+1 is read
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_SCAN: begin
				cmd.rd = 1'b1;
				cmd.chk = !first_q;
			end
			S_LAST: cmd.chk = 1'b1;
			S_WR:   cmd.wr = 1'b1;
			S_RSP:  cmd.rsp = 1'b1;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			first_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					state_q <= S_SCAN;
					first_q <= 1'b1;
				end
				S_SCAN: begin
					first_q <= 1'b0;
					if (sts.last) state_q <= S_LAST;
				end
				S_LAST: state_q <= S_WR;
				S_WR:   state_q <= S_RSP;
				S_RSP:  state_q <= S_OUT;
				S_OUT:  if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ verif/aging_route_table_top_test.sv @@
`timescale 1ns / 1ps
module aging_route_table_top_test;
	import art_pkg::*;

	localparam int DEPTH = 32;
	localparam int NUM_RANDOM = 1260;
	localparam int LATENCY = DEPTH + 10;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	req_t in_data;
	logic out_valid;
	logic out_stall;
	rsp_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [15:0] cfg_data;

	aging_route_table_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// route table copy
	logic [15:0] stale_secs;
	logic        rt_valid [DEPTH];
	logic [31:0] rt_ip [DEPTH];
	logic [47:0] rt_mac [DEPTH];
	logic [7:0]  rt_hops [DEPTH];
	logic [7:0]  rt_iface [DEPTH];
	logic [31:0] rt_stamp [DEPTH];

	rsp_t route_rsp_q[$];
	int errors = 0;

	// address pool keeps updates hitting existing routes
	logic [31:0] ip_pool [8];
	logic [31:0] clock_s;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("aging_route_table_top test failed");
		$finish;
	end

	function automatic rsp_t route_report(status_t st, int slot);
		rsp_t r;
		r = '0;
		r.status = st;
		if (slot >= 0) begin
			r.found_hops = rt_hops[slot];
			r.found_mac = rt_mac[slot];
			r.found_iface = rt_iface[slot];
		end
		return r;
	endfunction

	function automatic rsp_t route_apply(req_t q);
		int slot;
		int idle_slot;
		slot = -1;
		idle_slot = -1;
		for (int i = 0; i < DEPTH; i++) begin
			if (rt_valid[i] && (q.now_seconds - rt_stamp[i]) > {16'd0, stale_secs})
				rt_valid[i] = 1'b0;
		end
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (rt_valid[i] && rt_ip[i] == q.dest_ip)
				slot = i;
			if (!rt_valid[i])
				idle_slot = i;
		end
		if (q.cmd == CMD_LOOKUP)
			return route_report(slot >= 0 ? ST_FOUND : ST_NOT_FOUND, slot);
		if (slot < 0) begin
			if (idle_slot < 0)
				return route_report(ST_FULL, -1);
			rt_valid[idle_slot] = 1'b1;
			rt_ip[idle_slot] = q.dest_ip;
			rt_mac[idle_slot] = q.next_hop_mac;
			rt_hops[idle_slot] = q.hops;
			rt_iface[idle_slot] = q.iface;
			rt_stamp[idle_slot] = q.now_seconds;
			return route_report(ST_INSERTED, idle_slot);
		end
		if (rt_hops[slot] == q.hops) begin
			rt_mac[slot] = q.next_hop_mac;
			rt_iface[slot] = q.iface;
			rt_stamp[slot] = q.now_seconds;
			return route_report(ST_REFRESHED, slot);
		end
		if (rt_hops[slot] > q.hops) begin
			rt_mac[slot] = q.next_hop_mac;
			rt_hops[slot] = q.hops;
			rt_iface[slot] = q.iface;
			rt_stamp[slot] = q.now_seconds;
			return route_report(ST_IMPROVED, slot);
		end
		return route_report(ST_IGNORED, slot);
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50)
			return 0;
		if (p < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 80);
	endfunction

	// output side: random stall runs, check each transfer
	initial begin
		int stall_left;
		rsp_t exp_rsp;
		stall_left = 0;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (route_rsp_q.size() == 0) begin
					$error("unexpected transfer %h", out_data);
					errors++;
				end else begin
					exp_rsp = route_rsp_q.pop_front();
					if (out_data.status !== exp_rsp.status) begin
						$error("status exp %0d got %0d", exp_rsp.status, out_data.status);
						errors++;
					end
					if (out_data.found_hops !== exp_rsp.found_hops) begin
						$error("found_hops exp %0d got %0d", exp_rsp.found_hops,
							out_data.found_hops);
						errors++;
					end
					if (out_data.found_mac !== exp_rsp.found_mac) begin
						$error("found_mac exp %h got %h", exp_rsp.found_mac, out_data.found_mac);
						errors++;
					end
					if (out_data.found_iface !== exp_rsp.found_iface) begin
						$error("found_iface exp %0d got %0d", exp_rsp.found_iface,
							out_data.found_iface);
						errors++;
					end
				end
			end
			if (stall_left > 0)
				stall_left--;
			else if ($urandom_range(0, 3) == 0)
				stall_left = gap_len();
			out_stall <= (stall_left > 0);
		end
	end

	// valid drops only when a gap follows, so back-to-back sends keep it high
	task automatic send_req(req_t q, bit chk_fixed, rsp_t fixed_rsp);
		rsp_t r;
		int n;
		n = gap_len();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= q;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		r = route_apply(q);
		if (chk_fixed && r !== fixed_rsp) begin
			$error("table row exp %h predicted %h", fixed_rsp, r);
			errors++;
		end
		route_rsp_q.push_back(r);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (route_rsp_q.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_stale(logic [15:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		stale_secs = v;
	endtask

	function automatic req_t mk_req(logic c, logic [31:0] ip, logic [47:0] mac,
		logic [7:0] h, logic [7:0] ifc, logic [31:0] t);
		req_t q;
		q.cmd = c;
		q.dest_ip = ip;
		q.next_hop_mac = mac;
		q.hops = h;
		q.iface = ifc;
		q.now_seconds = t;
		return q;
	endfunction

	function automatic rsp_t mk_rsp(status_t st, logic [7:0] h, logic [47:0] mac,
		logic [7:0] ifc);
		rsp_t r;
		r.status = st;
		r.found_hops = h;
		r.found_mac = mac;
		r.found_iface = ifc;
		return r;
	endfunction

	typedef struct {
		req_t q;
		bit   chk;
		rsp_t r;
	} stim_row_t;

	stim_row_t rows[$];

	task automatic random_phase(int cnt, int pool_n);
		req_t q;
		for (int k = 0; k < cnt; k++) begin
			if ($urandom_range(0, 9) < 7)
				clock_s = clock_s + $urandom_range(0, 3);
			else if ($urandom_range(0, 4) == 0)
				clock_s = $urandom;
			q.cmd = $urandom_range(0, 2) == 0 ? CMD_LOOKUP : CMD_UPDATE;
			q.dest_ip = $urandom_range(0, 9) < 8 ? ip_pool[$urandom_range(0, pool_n - 1)]
				: $urandom;
			q.next_hop_mac = 48'({$urandom, $urandom});
			q.hops = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 6));
			q.iface = 8'($urandom);
			q.now_seconds = clock_s;
			send_req(q, 1'b0, '0);
		end
	endtask

	initial begin
		stim_row_t row;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		stale_secs = StaleReset;
		for (int i = 0; i < DEPTH; i++) begin
			rt_valid[i] = 1'b0;
			rt_ip[i] = '0;
			rt_mac[i] = '0;
			rt_hops[i] = '0;
			rt_iface[i] = '0;
			rt_stamp[i] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows.push_back('{mk_req(CMD_LOOKUP, 32'h0, '0, 0, 0, 0), 1,
			mk_rsp(ST_NOT_FOUND, 0, 0, 0)});
		rows.push_back('{mk_req(CMD_UPDATE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 8'hFF, 8'hFF,
			32'hFFFF_FFF0), 1, mk_rsp(ST_INSERTED, 8'hFF, 48'hFFFF_FFFF_FFFF, 8'hFF)});
		rows.push_back('{mk_req(CMD_UPDATE, 32'hFFFF_FFFF, 48'h1, 8'hFF, 8'h0,
			32'hFFFF_FFF8), 1, mk_rsp(ST_REFRESHED, 8'hFF, 48'h1, 8'h0)});
		rows.push_back('{mk_req(CMD_UPDATE, 32'hFFFF_FFFF, 48'h2, 8'h00, 8'h7,
			32'h0000_0004), 1, mk_rsp(ST_IMPROVED, 8'h0, 48'h2, 8'h7)});
		rows.push_back('{mk_req(CMD_UPDATE, 32'hFFFF_FFFF, 48'h3, 8'h01, 8'h9,
			32'h0000_0005), 1, mk_rsp(ST_IGNORED, 8'h0, 48'h2, 8'h7)});
		rows.push_back('{mk_req(CMD_LOOKUP, 32'hFFFF_FFFF, 48'hABCD, 8'h5, 8'h5,
			32'h0000_0018), 1, mk_rsp(ST_FOUND, 8'h0, 48'h2, 8'h7)});
		// age 21 > 20: purged
		rows.push_back('{mk_req(CMD_LOOKUP, 32'hFFFF_FFFF, '0, 0, 0, 32'h0000_0019), 1,
			mk_rsp(ST_NOT_FOUND, 0, 0, 0)});
		rows.push_back('{mk_req(CMD_UPDATE, 32'h0, 48'hAAAA_5555_AAAA, 8'hAA, 8'h55,
			32'h0000_0019), 1, mk_rsp(ST_INSERTED, 8'hAA, 48'hAAAA_5555_AAAA, 8'h55)});
		rows.push_back('{mk_req(CMD_LOOKUP, 32'h1, '0, 0, 0, 32'h0000_0019), 1,
			mk_rsp(ST_NOT_FOUND, 0, 0, 0)});
		foreach (rows[i]) begin
			row = rows[i];
			send_req(row.q, row.chk, row.r);
		end

		// fill the table, then one more is full
		write_stale(16'hFFFF);
		for (int i = 0; i < DEPTH; i++)
			send_req(mk_req(CMD_UPDATE, 32'h1000 + i, 48'({$urandom, $urandom}),
				8'($urandom), 8'($urandom), 32'h100), 1'b0, '0);
		send_req(mk_req(CMD_UPDATE, 32'h5555_AAAA, 48'h5, 8'h1, 8'h1, 32'h101), 1'b1,
			mk_rsp(ST_FULL, 0, 0, 0));

		// zero threshold: live only at same second
		write_stale(16'd0);
		send_req(mk_req(CMD_UPDATE, 32'h77, 48'h77, 8'h3, 8'h4, 32'h200), 1'b1,
			mk_rsp(ST_INSERTED, 8'h3, 48'h77, 8'h4));
		send_req(mk_req(CMD_LOOKUP, 32'h77, '0, 0, 0, 32'h200), 1'b1,
			mk_rsp(ST_FOUND, 8'h3, 48'h77, 8'h4));
		send_req(mk_req(CMD_LOOKUP, 32'h77, '0, 0, 0, 32'h201), 1'b1,
			mk_rsp(ST_NOT_FOUND, 0, 0, 0));

		clock_s = $urandom;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_stale(16'd20);
				1: write_stale(16'd0);
				2: write_stale(16'hFFFF);
				3: write_stale(16'($urandom_range(2, 12)));
				4: write_stale(16'($urandom));
				default: write_stale(16'd5);
			endcase
			for (int i = 0; i < 8; i++)
				ip_pool[i] = $urandom;
			random_phase(NUM_RANDOM / 6, ph == 2 ? 8 : $urandom_range(2, 8));
			if (ph == 2)
				random_phase(40, 1);
		end
		// overfill with many distinct addresses
		random_phase(0, 1);
		for (int i = 0; i < 40; i++)
			send_req(mk_req(CMD_UPDATE, $urandom, 48'({$urandom, $urandom}), 8'($urandom),
				8'($urandom), clock_s), 1'b0, '0);

		drain();
		if (errors == 0) begin
			$display("aging_route_table_top test passed");
		end else begin
			$display("aging_route_table_top test failed");
		end
		$finish;
	end

endmodule

@@ aging_route_table_top.f @@
hdl/art_pkg.sv
hdl/art_datapath.sv
hdl/art_ctrl.sv
hdl/aging_route_table_top.sv
verif/aging_route_table_top_test.sv
